### rtl/packet_departure_pacer_defines.svh
// Assertion macros shared by the pacer RTL.
`ifndef PACKET_DEPARTURE_PACER_DEFINES_SVH
`define PACKET_DEPARTURE_PACER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PDP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define PDP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/pdp_pkg.sv
// Constants and types for the packet departure pacer.
`default_nettype none
package pdp_pkg;
	localparam int TIME_W  = 64;
	localparam int LEAD_W  = 32;
	localparam int OVH_W   = 16;
	localparam int LEN_W   = 16;
	localparam int RATE_W  = 39;
	localparam int WIRE_W  = 17;
	localparam int SCALE_W = 33;
	localparam int NUM_W   = WIRE_W + SCALE_W;
	localparam int IDX_W   = 2;

	localparam logic [SCALE_W-1:0] BYTE_NS = 33'd8000000000;

	localparam logic [IDX_W-1:0] CFG_LEAD_TIME = 2'd0;
	localparam logic [IDX_W-1:0] CFG_OVERHEAD  = 2'd1;
	localparam logic [IDX_W-1:0] CFG_LINE_RATE = 2'd2;

	typedef logic [TIME_W-1:0] time_ns_t;
endpackage
`default_nettype wire

### rtl/packet_departure_pacer.sv
// Packet departure pacer: earliest-departure-time scheduler with serial divider.
//
// Input channel (in_valid / in_stall): one request per beat. req_type 0 schedules a
// packet of payload_len bytes at now_time; req_type 1 clears the next free time and
// returns nothing. Output channel (out_valid / out_stall): one depart_time beat per
// schedule request, in request order. Configuration channel (cfg_valid / cfg_ready):
// index 0 lead_time, 1 overhead_bytes, 2 line_rate; other indexes are ignored.
//
// A schedule request holds the block through accept, multiply, 50 radix-2 divide steps
// and finish; depart_time is registered in the finish step, and the next request is
// taken once the block is back in idle. With line_rate 0 the divide is skipped and the
// block goes from multiply straight to finish. The 50-bit numerator of the restoring
// divider sets the number of divide steps. A reset request clears the next free time
// without leaving idle. in_stall is high while a request is in flight.
// The result sits in an output register, so a new request is accepted while it waits;
// a stalled receiver only holds the finish step of the following request.
// Reset clears the configuration registers, the next free time and the output valid.
`default_nettype none
module packet_departure_pacer
	import pdp_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output      logic                in_stall,
	input  wire logic                req_type,
	input  wire logic [TIME_W-1:0]   now_time,
	input  wire logic [LEN_W-1:0]    payload_len,
	output      logic                out_valid,
	input  wire logic                out_stall,
	output      logic [TIME_W-1:0]   depart_time,
	input  wire logic                cfg_valid,
	output      logic                cfg_ready,
	input  wire logic [IDX_W-1:0]    cfg_index,
	input  wire logic [RATE_W-1:0]   cfg_data
);

	`include "packet_departure_pacer_defines.svh"

	localparam int CNT_W = $clog2(NUM_W);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0]        state_q;
	logic [LEAD_W-1:0] lead_q;
	logic [OVH_W-1:0]  ovh_q;
	logic [RATE_W-1:0] rate_q;
	time_ns_t          nfree_q;
	time_ns_t          earliest_q;
	time_ns_t          depart_q;
	time_ns_t          out_q;
	logic              out_valid_q;
	logic [WIRE_W-1:0] wire_q;
	logic [NUM_W-1:0]  num_q;
	logic [RATE_W-1:0] rem_q;
	logic [CNT_W-1:0]  cnt_q;

	logic              in_acc;
	logic              fin_go;
	logic [TIME_W:0]   lead_sum;
	time_ns_t          earliest_d;
	logic [NUM_W-1:0]  prod;
	logic [RATE_W:0]   trial;
	logic              trial_ge;
	logic [RATE_W:0]   trial_sub;
	time_ns_t          interval;
	logic [TIME_W:0]   free_sum;
	time_ns_t          free_d;

	assign in_stall    = (state_q != ST_IDLE);
	assign in_acc      = in_valid && !in_stall;
	assign cfg_ready   = 1'b1;
	assign out_valid   = out_valid_q;
	assign depart_time = out_q;
	assign fin_go      = (state_q == ST_FIN) && (!out_valid_q || !out_stall);

	assign lead_sum   = {1'b0, now_time} + {{(TIME_W-LEAD_W+1){1'b0}}, lead_q};
	assign earliest_d = lead_sum[TIME_W] ? {TIME_W{1'b1}} : lead_sum[TIME_W-1:0];

	assign prod = {{(NUM_W-WIRE_W){1'b0}}, wire_q} * {{(NUM_W-SCALE_W){1'b0}}, BYTE_NS};

	assign trial     = {rem_q, num_q[NUM_W-1]};
	assign trial_ge  = (trial >= {1'b0, rate_q});
	assign trial_sub = trial - {1'b0, rate_q};

	always_comb begin
		if (rate_q == '0) begin
			interval = '0;
		end else begin
			interval = {{(TIME_W-NUM_W){1'b0}}, num_q}
				+ {{(TIME_W-1){1'b0}}, (rem_q != '0)};
		end
	end

	assign free_sum = {1'b0, depart_q} + {1'b0, interval};
	assign free_d   = free_sum[TIME_W] ? {TIME_W{1'b1}} : free_sum[TIME_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q <= '0;
			ovh_q  <= '0;
			rate_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_LEAD_TIME: lead_q <= cfg_data[LEAD_W-1:0];
				CFG_OVERHEAD:  ovh_q  <= cfg_data[OVH_W-1:0];
				CFG_LINE_RATE: rate_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			nfree_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (req_type) begin
							nfree_q <= '0;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					state_q <= (rate_q == '0) ? ST_FIN : ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == CNT_W'(NUM_W - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						nfree_q <= free_d;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			earliest_q <= earliest_d;
			wire_q     <= {1'b0, payload_len} + {1'b0, ovh_q};
		end
		if (state_q == ST_MUL) begin
			num_q    <= prod;
			depart_q <= (nfree_q > earliest_q) ? nfree_q : earliest_q;
			rem_q    <= '0;
			cnt_q    <= '0;
		end
		if (state_q == ST_DIV) begin
			num_q <= {num_q[NUM_W-2:0], trial_ge};
			rem_q <= trial_ge ? trial_sub[RATE_W-1:0] : trial[RATE_W-1:0];
			cnt_q <= cnt_q + 1'b1;
		end
		if (fin_go) begin
			out_q <= depart_q;
		end
	end

	`PDP_ASSERT_NOW(a_busy_stalls, (state_q != ST_IDLE), in_stall, "request taken while busy")
	`PDP_ASSERT_NOW(a_load_from_fin, $rose(out_valid_q), ($past(state_q) == ST_FIN),
		"result loaded outside finish step")
	`PDP_ASSERT_NOW(a_div_bound, (state_q == ST_DIV), (cnt_q < CNT_W'(NUM_W)),
		"divide step count overrun")
	`PDP_ASSERT_NEXT(a_reset_clears, (in_acc && req_type), (nfree_q == '0),
		"reset request left next free time set")

endmodule
`default_nettype wire

### tb/sv/pacer_departure_checker.sv
// Departure-time predictor and scoreboard for the packet departure pacer.
`default_nettype none
module pacer_departure_checker
	import pdp_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              in_stall,
	input  wire logic              req_type,
	input  wire logic [TIME_W-1:0] now_time,
	input  wire logic [LEN_W-1:0]  payload_len,
	input  wire logic              out_valid,
	input  wire logic              out_stall,
	input  wire logic [TIME_W-1:0] depart_time,
	input  wire logic              cfg_valid,
	input  wire logic              cfg_ready,
	input  wire logic [IDX_W-1:0]  cfg_index,
	input  wire logic [RATE_W-1:0] cfg_data,
	output int                     mismatches,
	output int                     outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [LEAD_W-1:0] lead_ns;
	logic [OVH_W-1:0]  wire_overhead;
	logic [RATE_W-1:0] pace_rate;
	time_ns_t          free_at;
	time_ns_t          departures_due[$];
	time_ns_t          earliest;
	time_ns_t          slot;
	time_ns_t          want;

	function automatic time_ns_t clamp_sum(input time_ns_t a, input time_ns_t b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TIME_W] ? '1 : s[TIME_W-1:0];
	endfunction

	// ceil(wire bytes * 8e9 / rate), zero when the rate is zero
	function automatic time_ns_t pacing_gap(input logic [LEN_W-1:0] len);
		logic [TIME_W-1:0] bits_ns;
		if (pace_rate == '0)
			return '0;
		bits_ns = (TIME_W'(len) + TIME_W'(wire_overhead)) * TIME_W'(BYTE_NS);
		return (bits_ns + TIME_W'(pace_rate) - 1) / TIME_W'(pace_rate);
	endfunction

	task automatic report_mismatch(input string what);
		$display("%0t ns: departure mismatch: %s", $time, what);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_ns       <= '0;
			wire_overhead <= '0;
			pace_rate     <= '0;
			free_at       <= '0;
			departures_due.delete();
			mismatches  = 0;
			outstanding = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_LEAD_TIME: lead_ns       <= cfg_data[LEAD_W-1:0];
					CFG_OVERHEAD:  wire_overhead <= cfg_data[OVH_W-1:0];
					CFG_LINE_RATE: pace_rate     <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (departures_due.size() == 0) begin
					report_mismatch($sformatf("unexpected beat, depart_time %0d", depart_time));
				end else begin
					want = departures_due.pop_front();
					if (depart_time !== want)
						report_mismatch($sformatf("depart_time %0d, want %0d", depart_time, want));
				end
			end
			if (in_valid && !in_stall) begin
				if (req_type) begin
					free_at <= '0;
				end else begin
					earliest = clamp_sum(now_time, TIME_W'(lead_ns));
					slot     = (free_at > earliest) ? free_at : earliest;
					departures_due.push_back(slot);
					free_at <= clamp_sum(slot, pacing_gap(payload_len));
				end
			end
			outstanding = departures_due.size();
		end
	end
endmodule
`default_nettype wire

### tb/sv/tb_packet_departure_pacer.sv
// Stimulus and verdict for the packet departure pacer testbench.
`default_nettype none
module tb_packet_departure_pacer
	import pdp_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [IDX_W-1:0]  CFG_SPARE     = 2'd3;
	localparam time_ns_t          TIME_MAX      = '1;
	localparam logic [RATE_W-1:0] RATE_TOP      = 39'd400000000000;
	localparam logic [RATE_W-1:0] RATE_ALL      = '1;
	localparam int                SETTLE_CYCLES = 60;
	localparam int                PHASES        = 10;
	localparam int                PHASE_ITEMS   = 130;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic              req_type;
	time_ns_t          now_time;
	logic [LEN_W-1:0]  payload_len;
	logic              out_valid;
	logic              out_stall;
	time_ns_t          depart_time;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [IDX_W-1:0]  cfg_index;
	logic [RATE_W-1:0] cfg_data;
	int                mismatches;
	int                outstanding;
	logic              steady;
	time_ns_t          wall_ns;
	int unsigned       wall_pick;
	logic [RATE_W-1:0] lead_cfg;
	logic [RATE_W-1:0] ovh_cfg;
	logic [RATE_W-1:0] rate_cfg;
	logic [LEN_W-1:0]  len_pick;

	always #5 clk = ~clk;

	packet_departure_pacer u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.now_time    (now_time),
		.payload_len (payload_len),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.depart_time (depart_time),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	pacer_departure_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.now_time    (now_time),
		.payload_len (payload_len),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.depart_time (depart_time),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always @(negedge clk) begin
		out_stall <= !steady && ($urandom_range(0, 99) < 30);
	end

	task automatic push_request(input logic rt, input time_ns_t t, input logic [LEN_W-1:0] len);
		@(negedge clk);
		while (!steady && $urandom_range(0, 99) < 30) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		req_type    <= rt;
		now_time    <= t;
		payload_len <= len;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic schedule(input time_ns_t t, input logic [LEN_W-1:0] len);
		push_request(1'b0, t, len);
	endtask

	task automatic clear_pacing(input time_ns_t t, input logic [LEN_W-1:0] len);
		push_request(1'b1, t, len);
	endtask

	// hold off until every departure is back, then let the block settle
	task automatic wait_drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [RATE_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic apply_setting(input logic [RATE_W-1:0] lead, input logic [RATE_W-1:0] ovh,
			input logic [RATE_W-1:0] rate);
		write_reg(CFG_LEAD_TIME, lead);
		write_reg(CFG_OVERHEAD, ovh);
		write_reg(CFG_LINE_RATE, rate);
		write_reg(CFG_SPARE, RATE_W'({$urandom, $urandom}));
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		#10ms;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		req_type    = 1'b0;
		now_time    = '0;
		payload_len = '0;
		out_stall   = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = CFG_LEAD_TIME;
		cfg_data    = '0;
		steady      = 1'b0;
		wall_ns     = '0;
		wall_pick   = 0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// zero rate: no spacing, the largest plain time passes through
		apply_setting('0, '0, '0);
		schedule('0, '0);
		schedule(TIME_MAX, '1);
		schedule('0, '0);
		clear_pacing(TIME_MAX, '1);
		schedule(5, 1);

		// widest registers, lead saturates, garbage above the lead and overhead fields
		wait_drain();
		apply_setting(RATE_ALL, RATE_ALL, RATE_ALL);
		schedule(TIME_MAX - 10, '0);
		clear_pacing('0, '0);
		schedule(100, '1);
		schedule(100, '0);
		schedule('0, 1);

		// slowest rate, interval add saturates
		wait_drain();
		apply_setting(1000, 24, 1);
		schedule('0, '1);
		schedule(TIME_MAX - 5, 10);
		schedule('0, '0);
		clear_pacing(TIME_MAX, '0);
		schedule(7, '0);

		// top of the rated range
		wait_drain();
		apply_setting('0, '0, RATE_TOP);
		schedule('0, 1500);
		schedule(1, 64);
		schedule(2, '1);
		schedule(3, '0);

		for (int p = 0; p < PHASES; p++) begin
			wait_drain();
			steady = (p == 4);
			case ($urandom_range(0, 3))
				0: lead_cfg = '0;
				1: lead_cfg = 39'hFFFF_FFFF;
				2: lead_cfg = RATE_W'($urandom_range(0, 10000));
				default: lead_cfg = {7'($urandom), 32'($urandom)};
			endcase
			case ($urandom_range(0, 3))
				0: ovh_cfg = '0;
				1: ovh_cfg = 39'hFFFF;
				2: ovh_cfg = RATE_W'($urandom_range(0, 100));
				default: ovh_cfg = {23'($urandom), 16'($urandom)};
			endcase
			case ($urandom_range(0, 5))
				0: rate_cfg = '0;
				1: rate_cfg = RATE_W'($urandom_range(1, 1000));
				2: rate_cfg = RATE_TOP;
				3: rate_cfg = RATE_ALL;
				4: rate_cfg = RATE_W'(64'd1000000 + ({$urandom, $urandom} % 64'd400000000000));
				default: rate_cfg = RATE_W'({$urandom, $urandom});
			endcase
			apply_setting(lead_cfg, ovh_cfg, rate_cfg);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if ($urandom_range(0, 199) == 0)
					wait_drain();
				wall_pick = $urandom_range(0, 99);
				if (wall_pick < 90)
					wall_ns = wall_ns + TIME_W'($urandom_range(0, 3000));
				else if (wall_pick < 95)
					wall_ns = {$urandom, $urandom};
				else
					wall_ns = TIME_MAX - TIME_W'($urandom_range(0, 100000));
				len_pick = ($urandom_range(0, 99) < 20) ? LEN_W'($urandom_range(0, 1500))
					: LEN_W'($urandom);
				push_request($urandom_range(0, 99) < 8, wall_ns, len_pick);
			end
		end
		steady = 1'b0;

		wait_drain();
		if (mismatches == 0 && outstanding == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
`default_nettype wire
